>>> hdl/water_ripple_height_step_defines.svh
// Assertion macros for the ripple height step.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef WATER_RIPPLE_HEIGHT_STEP_DEFINES_SVH
`define WATER_RIPPLE_HEIGHT_STEP_DEFINES_SVH

// Same-cycle implication.
`define WRHS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WRHS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/wrhs_pkg.sv
package wrhs_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int SUM_BITS      = SAMPLE_BITS + 3;
   localparam int VALUE_BITS    = SAMPLE_BITS + 4;
   localparam int CSR_DATA_BITS = 11;
   localparam int MIN_SIZE      = 3;

   localparam logic [CSR_DATA_BITS-1:0] FRAME_WIDTH_RESET  = 11'd320;
   localparam logic [CSR_DATA_BITS-1:0] FRAME_HEIGHT_RESET = 11'd240;
   localparam logic [3:0]               DAMPING_RESET      = 4'd2;
   localparam logic                     SMOOTH_RESET       = 1'b0;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_DAMPING_SHIFT = 2'd2,
      CSR_SMOOTH_MODE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] current_height;
      logic signed [SAMPLE_BITS-1:0] older_height;
      logic                          pad;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] new_height;
      logic                          is_border;
      logic                          last;
   } rsp_payload_type;

endpackage

>>> hdl/water_ripple_height_step.sv
// Channel    | Handshake             | Payload                  | Direction
// -----------+-----------------------+--------------------------+----------
// req        | req_valid / req_ready | req_data (heights, pad)  | in
// rsp        | rsp_valid / rsp_ready | rsp_data (height, flags) | out
// csr        | csr_valid / csr_ready | csr_index, csr_data      | in
//
// One pixel per clock sustained while rsp_ready stays high. An item passes the line
// memory reads, the window, the neighbor sum, the neighbor/older combine and the
// damping stage, which loads the output register.
// The first W+1 items of a frame give no result; W+1 pad items flush the tail.
// Reset is synchronous; the line memories hold no reset and need no clearing pass.
// Stages hold while the output register waits, empty stages still take data.
`include "water_ripple_height_step_defines.svh"

module water_ripple_height_step #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  wrhs_pkg::req_payload_type     req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wrhs_pkg::rsp_payload_type     rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  wrhs_pkg::csr_index_type       csr_index,
   input  logic [wrhs_pkg::CSR_DATA_BITS-1:0] csr_data
);

   import wrhs_pkg::*;

   // column index, width up to W+1, ring pointer 0..W, row index, height
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = $clog2(MAX_WIDTH + 2);
   localparam int DW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   localparam logic signed [VALUE_BITS-1:0] SAT_HI = VALUE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [VALUE_BITS-1:0] SAT_LO = -SAT_HI - VALUE_BITS'(1);

   function automatic logic [XW-1:0] clamp_w(input logic [CSR_DATA_BITS-1:0] raw);
      logic [31:0] v;
      v = 32'(raw);
      if (v < 32'(MIN_SIZE)) v = 32'(MIN_SIZE);
      else if (v > 32'(MAX_WIDTH)) v = 32'(MAX_WIDTH);
      return XW'(v);
   endfunction

   function automatic logic [HW-1:0] clamp_h(input logic [CSR_DATA_BITS-1:0] raw);
      logic [31:0] v;
      v = 32'(raw);
      if (v < 32'(MIN_SIZE)) v = 32'(MIN_SIZE);
      else if (v > 32'(MAX_HEIGHT)) v = 32'(MAX_HEIGHT);
      return HW'(v);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic signed [VALUE_BITS-1:0] v);
      logic signed [VALUE_BITS-1:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      else if (v < SAT_LO) r = SAT_LO;
      return r[SAMPLE_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------- config
   logic [XW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic [3:0]    damping_ff;
   logic          smooth_ff;

   assign csr_ready = 1'b1;

   // Store sizes already clamped; only the clamped value is ever used.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= clamp_w(FRAME_WIDTH_RESET);
         height_ff  <= clamp_h(FRAME_HEIGHT_RESET);
         damping_ff <= DAMPING_RESET;
         smooth_ff  <= SMOOTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   width_ff   <= clamp_w(csr_data);
            CSR_FRAME_HEIGHT:  height_ff  <= clamp_h(csr_data);
            CSR_DAMPING_SHIFT: damping_ff <= csr_data[3:0];
            CSR_SMOOTH_MODE:   smooth_ff  <= csr_data[0];
         endcase
      end
   end

   // ------------------------------------------------------- stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic ld_out, ld4, ld3, ld2, ld1;
   logic accept, s1_fire;

   // Each stage loads when it is empty or its content moves on.
   assign ld_out  = !rsp_valid_ff || rsp_ready;
   assign ld4     = !s4_valid_ff || ld_out;
   assign ld3     = !s3_valid_ff || ld4;
   assign ld2     = !s2_valid_ff || ld3;
   assign ld1     = !s1_valid_ff || ld2;
   assign req_ready = ld1;
   assign accept  = req_valid && ld1;
   assign s1_fire = s1_valid_ff && ld2;

   // ------------------------------------------------------ raster counters
   logic [CW-1:0] in_column_ff, in_column_in;
   logic [DW-1:0] delay_pos_ff, delay_pos_in;
   logic [XW-1:0] lead_ff, lead_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;

   logic [CW-1:0] col_eff;
   logic [XW-1:0] col_inc;
   logic [DW-1:0] dp_eff;
   logic [XW-1:0] dp_inc;
   logic          gen_result, gen_border, gen_last;
   logic          row_at_end, col_at_end;
   logic signed [SAMPLE_BITS-1:0] cur_height, old_height;

   assign cur_height = req_data.pad ? '0 : req_data.current_height;
   assign old_height = req_data.pad ? '0 : req_data.older_height;

   always_comb begin
      // Wrap a column or ring pointer left beyond a shrunken size.
      col_eff = (XW'(in_column_ff) >= width_ff) ? '0 : in_column_ff;
      col_inc = XW'(col_eff) + XW'(1);
      dp_eff  = (XW'(delay_pos_ff) > width_ff) ? '0 : delay_pos_ff;
      dp_inc  = XW'(dp_eff) + XW'(1);

      gen_result = !(lead_ff < width_ff + XW'(1));
      row_at_end = HW'(out_row_ff) >= height_ff - HW'(1);
      col_at_end = XW'(out_col_ff) >= width_ff - XW'(1);
      gen_border = (out_row_ff == '0) || row_at_end || (out_col_ff == '0) || col_at_end;
      gen_last   = gen_result && row_at_end && col_at_end;

      in_column_in = (col_inc >= width_ff) ? '0 : col_inc[CW-1:0];
      delay_pos_in = (dp_inc > width_ff) ? '0 : dp_inc[DW-1:0];
      lead_in      = gen_result ? lead_ff : lead_ff + XW'(1);
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;

      if (gen_last) begin
         // Frame done: restart every counter for the next frame.
         in_column_in = '0;
         delay_pos_in = '0;
         lead_in      = '0;
         out_row_in   = '0;
         out_col_in   = '0;
      end else if (gen_result) begin
         if (XW'(out_col_ff) + XW'(1) >= width_ff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + RW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         delay_pos_ff <= '0;
         lead_ff      <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
      end else if (accept) begin
         in_column_ff <= in_column_in;
         delay_pos_ff <= delay_pos_in;
         lead_ff      <= lead_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
      end
   end

   // --------------------------------------------------------------- memories
   // mid_mem holds the previous row, top_mem the row before it, older_mem the
   // ring of W+1 older heights. All reads are registered.
   logic signed [SAMPLE_BITS-1:0] mid_mem   [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] top_mem   [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH + 1];

   logic signed [SAMPLE_BITS-1:0] mid_q_ff, top_q_ff, older_q_ff;
   logic [CW-1:0]                 s1_col_ff;
   logic                          top_fwd;

   // The top row write trails the read by one stage; when the next item hits
   // the same column (frame restart), forward the pending write data.
   assign top_fwd = s1_valid_ff && (s1_col_ff == col_eff);

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_q_ff           <= mid_mem[col_eff];
         mid_mem[col_eff]   <= cur_height;
         top_q_ff           <= top_fwd ? mid_q_ff : top_mem[col_eff];
         older_q_ff         <= older_mem[dp_eff];
         older_mem[dp_eff]  <= old_height;
      end
      if (s1_fire) begin
         top_mem[s1_col_ff] <= mid_q_ff;
      end
   end

   // --------------------------------------------------------------- stage 1
   logic signed [SAMPLE_BITS-1:0] s1_cur_ff;
   logic                          s1_res_ff, s1_border_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= col_eff;
         s1_cur_ff    <= cur_height;
         s1_res_ff    <= gen_result;
         s1_border_ff <= gen_border;
         s1_last_ff   <= gen_last;
      end
   end

   // ---------------------------------------------------- window, stage 2
   logic signed [SAMPLE_BITS-1:0] win_ff [3][3];
   logic signed [SAMPLE_BITS-1:0] s2_od_ff;
   logic                          s2_border_ff, s2_last_ff;

   // Shift the window left and drop the new column in on the right.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= top_q_ff;
         win_ff[1][2] <= mid_q_ff;
         win_ff[2][2] <= s1_cur_ff;
         s2_od_ff     <= older_q_ff;
         s2_border_ff <= s1_border_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // --------------------------------------------------------------- stage 3
   logic signed [SUM_BITS-1:0]    neighbor_sum;
   logic signed [SUM_BITS-1:0]    s3_sum_ff;
   logic signed [SAMPLE_BITS-1:0] s3_od_ff;
   logic                          s3_border_ff, s3_last_ff;

   assign neighbor_sum = SUM_BITS'(win_ff[0][0]) + SUM_BITS'(win_ff[0][1])
                       + SUM_BITS'(win_ff[0][2]) + SUM_BITS'(win_ff[1][0])
                       + SUM_BITS'(win_ff[1][2]) + SUM_BITS'(win_ff[2][0])
                       + SUM_BITS'(win_ff[2][1]) + SUM_BITS'(win_ff[2][2]);

   always_ff @(posedge clock) begin
      if (s2_valid_ff && ld3) begin
         s3_sum_ff    <= neighbor_sum;
         s3_od_ff     <= s2_od_ff;
         s3_border_ff <= s2_border_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   // --------------------------------------------------------------- stage 4
   logic signed [VALUE_BITS-1:0] sum_x, od_x, ripple_n, smooth_v, s4_val_in;
   logic signed [VALUE_BITS-1:0] s4_val_ff;
   logic                         s4_damp_in, s4_damp_ff, s4_border_ff, s4_last_ff;

   always_comb begin
      sum_x    = VALUE_BITS'(s3_sum_ff);
      od_x     = VALUE_BITS'(s3_od_ff);
      ripple_n = (sum_x >>> 2) - od_x;
      smooth_v = ((sum_x >>> 3) + od_x) >>> 1;
      // Border: pass the older height; smooth: no damping; ripple: damp in the next stage.
      if (s3_border_ff) begin
         s4_val_in  = od_x;
         s4_damp_in = 1'b0;
      end else if (smooth_ff) begin
         s4_val_in  = smooth_v;
         s4_damp_in = 1'b0;
      end else begin
         s4_val_in  = ripple_n;
         s4_damp_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && ld4) begin
         s4_val_ff    <= s4_val_in;
         s4_damp_ff   <= s4_damp_in;
         s4_border_ff <= s3_border_ff;
         s4_last_ff   <= s3_last_ff;
      end
   end

   // --------------------------------------------------------- output stage
   logic signed [VALUE_BITS-1:0] final_v;
   rsp_payload_type              rsp_data_ff;

   assign final_v = s4_damp_ff ? s4_val_ff - (s4_val_ff >>> damping_ff) : s4_val_ff;

   always_ff @(posedge clock) begin
      if (s4_valid_ff && ld_out) begin
         rsp_data_ff.new_height <= saturate(final_v);
         rsp_data_ff.is_border  <= s4_border_ff;
         rsp_data_ff.last       <= s4_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ valid bits
   // Drop lead-in items at stage 2: they only fill the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1)    s1_valid_ff  <= accept;
         if (ld2)    s2_valid_ff  <= s1_valid_ff && s1_res_ff;
         if (ld3)    s3_valid_ff  <= s2_valid_ff;
         if (ld4)    s4_valid_ff  <= s3_valid_ff;
         if (ld_out) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // ------------------------------------------------------------ assertions
   `WRHS_ASSERT_NOW(a_last_on_border, rsp_valid && rsp_data.last, rsp_data.is_border, "last pixel not flagged border")
   `WRHS_ASSERT_NOW(a_ready_when_drained, !rsp_valid_ff, req_ready, "stalled with empty output register")
   `WRHS_ASSERT_NEXT(a_frame_restart, accept && gen_last, (in_column_ff == '0) && (lead_ff == '0), "counters not restarted after frame end")
   `WRHS_ASSERT_NEXT(a_top_forward, accept && top_fwd, top_q_ff == $past(mid_q_ff), "top row forward missed")

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import wrhs_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int MAX_W        = 1024;
   localparam int MAX_H        = 1024;
   localparam int RANDOM_ITEMS = 1750;
   localparam int HOLD_CYCLES  = 300;   // long output hold-off for the fill test
   localparam int DRAIN_CYCLES = 12;    // a bit over twice the pipeline depth
   localparam int STALL_LIMIT  = 4000;  // cycles with no transfer on any channel
   localparam int REPORT_LIMIT = 100;   // keep the log readable on a badly broken build

   typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_SMALL, FILL_PEAK_HIGH, FILL_PEAK_LOW}
      fill_kind_e;
   typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_style_e;

   // clock, reset and DUT ports; every input starts at a known value
   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   csr_index_type   csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   water_ripple_height_step #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------
   // Height field predictor: its own copy of the registers, line rows,
   // older-height delay ring and 3x3 window.
   // ------------------------------------------------------------------
   logic [CSR_DATA_BITS-1:0] width_csr, height_csr;
   logic [3:0]               damping_csr;
   logic                     smooth_csr;

   logic signed [SAMPLE_BITS-1:0] row_mem    [2*MAX_W];
   logic signed [SAMPLE_BITS-1:0] older_ring [MAX_W+1];
   logic signed [SAMPLE_BITS-1:0] window_px  [3][3];
   int unsigned col_in, row_out, col_out, lead_seen, ring_ptr;

   rsp_payload_type predicted_heights [$];

   // run statistics
   int fail_count;
   int pixels_sent, results_seen, frames_done;
   int border_seen, interior_seen, saturated_seen, input_stall_cycles;
   int quiet_cycles;

   function automatic int unsigned clamp_dim(input logic [CSR_DATA_BITS-1:0] v,
                                             input int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_ripple_frame();
      col_in    = 0;
      row_out   = 0;
      col_out   = 0;
      lead_seen = 0;
      ring_ptr  = 0;
   endfunction

   function automatic void reset_ripple_model();
      width_csr   = FRAME_WIDTH_RESET;
      height_csr  = FRAME_HEIGHT_RESET;
      damping_csr = DAMPING_RESET;
      smooth_csr  = SMOOTH_RESET;
      foreach (row_mem[i]) row_mem[i] = '0;
      foreach (older_ring[i]) older_ring[i] = '0;
      foreach (window_px[r, c]) window_px[r][c] = '0;
      restart_ripple_frame();
   endfunction

   function automatic void apply_csr_write(input csr_index_type idx,
                                           input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_FRAME_WIDTH:   width_csr   = value;
         CSR_FRAME_HEIGHT:  height_csr  = value;
         CSR_DAMPING_SHIFT: damping_csr = value[3:0];
         CSR_SMOOTH_MODE:   smooth_csr  = value[0];
         default: ;
      endcase
   endfunction

   // Advance the model by one pixel transfer; queue the height it releases, if any.
   function automatic void step_height_field(input req_payload_type item);
      int unsigned w, h, col, ptr;
      int r, nsum, damped, value;
      logic signed [SAMPLE_BITS-1:0] cur, old, top, mid, delayed_old;
      logic on_border;
      rsp_payload_type res;

      w   = clamp_dim(width_csr, MAX_W);
      h   = clamp_dim(height_csr, MAX_H);
      cur = item.pad ? '0 : item.current_height;
      old = item.pad ? '0 : item.older_height;

      // shift the two line rows and the window
      col = (col_in >= w) ? 0 : col_in;
      top = row_mem[MAX_W + col];
      mid = row_mem[col];
      row_mem[MAX_W + col] = mid;
      row_mem[col] = cur;
      for (r = 0; r < 3; r++) begin
         window_px[r][0] = window_px[r][1];
         window_px[r][1] = window_px[r][2];
      end
      window_px[0][2] = top;
      window_px[1][2] = mid;
      window_px[2][2] = cur;
      col_in = (col + 1 >= w) ? 0 : col + 1;

      // older heights come back W+1 transfers later
      ptr = (ring_ptr > w) ? 0 : ring_ptr;
      delayed_old = older_ring[ptr];
      older_ring[ptr] = old;
      ring_ptr = (ptr + 1 > w) ? 0 : ptr + 1;

      if (lead_seen < w + 1) begin
         lead_seen++;
         return;
      end

      res = '0;
      on_border = row_out == 0 || row_out >= h - 1 || col_out == 0 || col_out >= w - 1;
      res.last  = row_out >= h - 1 && col_out >= w - 1;
      res.is_border = on_border;

      if (on_border) begin
         value = delayed_old;
      end else begin
         nsum = window_px[0][0] + window_px[0][1] + window_px[0][2]
              + window_px[1][0] + window_px[1][2]
              + window_px[2][0] + window_px[2][1] + window_px[2][2];
         if (smooth_csr) begin
            value = ((nsum >>> 3) + delayed_old) >>> 1;
         end else begin
            damped = (nsum >>> 2) - delayed_old;
            value  = damped - (damped >>> damping_csr);
         end
      end

      // clip to the sample range
      if (value > 32767) begin
         value = 32767;
         saturated_seen++;
      end else if (value < -32768) begin
         value = -32768;
         saturated_seen++;
      end
      res.new_height = value[SAMPLE_BITS-1:0];
      predicted_heights.push_back(res);

      if (res.last) begin
         restart_ripple_frame();
      end else if (col_out + 1 >= w) begin
         col_out = 0;
         row_out++;
      end else begin
         col_out++;
      end
   endfunction

   function automatic void note_mismatch();
      fail_count++;
   endfunction

   // Compare one accepted result against the oldest prediction.
   function automatic void check_height(input rsp_payload_type got);
      rsp_payload_type want;
      results_seen++;
      if (predicted_heights.size() == 0) begin
         if (fail_count < REPORT_LIMIT)
            $error("unexpected result: new_height %0d is_border %0b last %0b",
                   got.new_height, got.is_border, got.last);
         note_mismatch();
         return;
      end
      want = predicted_heights.pop_front();
      if (want.is_border) border_seen++;
      else interior_seen++;
      if (want.last) frames_done++;
      // count silently past the report limit
      if (got.new_height !== want.new_height) begin
         if (fail_count < REPORT_LIMIT)
            $error("new_height: expected %0d, got %0d", want.new_height, got.new_height);
         note_mismatch();
      end
      if (got.is_border !== want.is_border) begin
         if (fail_count < REPORT_LIMIT)
            $error("is_border: expected %0b, got %0b", want.is_border, got.is_border);
         note_mismatch();
      end
      if (got.last !== want.last) begin
         if (fail_count < REPORT_LIMIT)
            $error("last: expected %0b, got %0b", want.last, got.last);
         note_mismatch();
      end
   endfunction

   // Watch every transfer at the clock edge; the pre-edge values are what the DUT saw.
   always @(posedge clock) begin
      if (reset) begin
         reset_ripple_model();
      end else begin
         if (csr_valid && csr_ready) apply_csr_write(csr_index, csr_data);
         if (req_valid && req_ready) step_height_field(req_data);
         if (req_valid && !req_ready) input_stall_cycles++;
         if (rsp_valid && rsp_ready) check_height(rsp_data);
      end
   end

   // Watchdog: end the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, predicted_heights.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result side: ready follows its own pattern; a test may request one
   // long hold-off, which this process times itself.
   // ------------------------------------------------------------------
   rx_style_e rx_style = RX_ALWAYS;
   int        rx_stall_pct = 30;
   bit        hold_request = 1'b0;
   bit        rx_on = 1'b1;
   int        rx_run = 0;
   int        holds_done = 0;

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         case (rx_style)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            default: begin
               // alternate runs of ready and stall with random lengths
               if (rx_run == 0) begin
                  rx_on  = !rx_on;
                  rx_run = rx_on ? $urandom_range(1, 24) : $urandom_range(1, 10);
               end
               rx_run--;
               rsp_ready <= rx_on;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pixel side: bursts of random length separated by random gaps.
   // ------------------------------------------------------------------
   int tx_gap_max = 0;
   int tx_burst_left = 0;

   task automatic send_pixel(input req_payload_type item);
      int gap;
      if (tx_burst_left == 0) begin
         tx_burst_left = $urandom_range(1, 32);
         gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      tx_burst_left--;
      // hold valid and payload until the transfer
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   // Drop valid, wait for every predicted height, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (predicted_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes keep one assignment per edge.
   task automatic write_reg(input csr_index_type idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] w,
                            input logic [CSR_DATA_BITS-1:0] h,
                            input logic [3:0] damping, input logic smooth);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_DAMPING_SHIFT, CSR_DATA_BITS'(damping));
      write_reg(CSR_SMOOTH_MODE, CSR_DATA_BITS'(smooth));
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_height(input fill_kind_e kind,
                                                                 input bit older);
      int v;
      case (kind)
         FILL_PEAK_HIGH: return older ? 16'sh8000 : 16'sh7FFF;
         FILL_PEAK_LOW:  return older ? 16'sh7FFF : 16'sh8000;
         FILL_SMALL: begin
            v = int'($urandom_range(0, 1023)) - 512;
            return v[SAMPLE_BITS-1:0];
         end
         FILL_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               3:       return 16'shFFFF;
               default: return SAMPLE_BITS'($urandom);
            endcase
         end
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // One whole frame at the current size, then W+1 flush items. Pixels inside
   // the frame are padded at pad_pct; the flush tail mixes pads and plain items.
   task automatic run_frame(input fill_kind_e kind, input int pad_pct);
      int unsigned w, h, i;
      req_payload_type item;
      w = clamp_dim(width_csr, MAX_W);
      h = clamp_dim(height_csr, MAX_H);
      for (i = 0; i < w * h + w + 1; i++) begin
         item.current_height = pick_height(kind, 1'b0);
         item.older_height   = pick_height(kind, 1'b1);
         if (i < w * h)
            // the peak frame pads its corner pixel so a zero enters the neighbor sum
            item.pad = (i == 0 && kind == FILL_PEAK_HIGH)
                       || ($urandom_range(0, 99) < pad_pct);
         else
            item.pad = $urandom_range(0, 1);
         send_pixel(item);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Smallest frame with damping and mode at their reset values: the center
   // saturates high, the ring of border pixels passes the older heights.
   task automatic test_reset_settings();
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_BITS'(MIN_SIZE));
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(MIN_SIZE));
      csr_valid <= 1'b0;
      rx_style   = RX_ALWAYS;
      tx_gap_max = 0;
      run_frame(FILL_PEAK_HIGH, 0);
      wait_idle();
   endtask

   // Smooth mode on the smallest frame with opposite peaks.
   task automatic test_smooth_pass();
      configure(CSR_DATA_BITS'(MIN_SIZE), CSR_DATA_BITS'(MIN_SIZE), 4'd15, 1'b1);
      rx_style   = RX_RANDOM;
      tx_gap_max = 3;
      run_frame(FILL_PEAK_LOW, 0);
      wait_idle();
   endtask

   // Sizes written beyond both ends clamp: a widest and a tallest frame, the other side at the minimum.
   task automatic test_size_extremes();
      configure(11'd2047, 11'd2, 4'd0, 1'b0);
      rx_style   = RX_BURSTY;
      tx_gap_max = 4;
      run_frame(FILL_EXTREME, 2);
      wait_idle();
      configure(11'd1, 11'd1024, 4'd15, 1'b1);
      rx_style   = RX_RANDOM;
      tx_gap_max = 0;
      run_frame(FILL_RANDOM, 2);
      wait_idle();
   endtask

   // Hold the output off for a long stretch while pixels keep coming, so the
   // pipeline fills and the input stalls.
   task automatic test_output_backpressure();
      configure(11'd16, 11'd6, 4'd4, 1'b0);
      rx_style     = RX_ALWAYS;
      tx_gap_max   = 0;
      hold_request = 1'b1;
      run_frame(FILL_RANDOM, 0);
      wait_idle();
   endtask

   // Random phases: new settings at each idle point, one to three frames each.
   task automatic test_random_frames();
      int start_count, frames;
      logic [CSR_DATA_BITS-1:0] w, h;
      logic [3:0] damping;
      start_count = pixels_sent;
      while (pixels_sent - start_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2);     // clamps to the minimum
            1:       w = $urandom_range(13, 40);
            default: w = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, 2);
            1:       h = $urandom_range(11, 20);
            default: h = $urandom_range(3, 10);
         endcase
         case ($urandom_range(0, 5))
            0:       damping = 4'd0;
            1:       damping = 4'd15;
            default: damping = $urandom_range(0, 15);
         endcase
         configure(w, h, damping, $urandom_range(0, 1));
         rx_style     = rx_style_e'($urandom_range(0, 2));
         rx_stall_pct = $urandom_range(10, 70);
         tx_gap_max   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         frames = $urandom_range(1, 3);
         // frames run back to back so each starts right after the last flag
         repeat (frames) run_frame(fill_kind_e'($urandom_range(0, 2)), $urandom_range(0, 10));
         wait_idle();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_smooth_pass();
      test_size_extremes();
      test_output_backpressure();
      test_random_frames();

      // everything is sent; wait out any stray results
      wait_idle();

      $display("Covered %0d pixel transfers, %0d results in %0d frames: %0d border, %0d interior,",
               pixels_sent, results_seen, frames_done, border_seen, interior_seen);
      $display("%0d clipped; ripple and smooth, damping 0..15, sizes 3 to 1024, %0d input stall cycles.",
               saturated_seen, input_stall_cycles);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
